// ----- src/kbrs_pkg.sv -----
// Package for the keypad row scanner: result type and fixed constants.
`default_nettype none
package kbrs_pkg;

  localparam int unsigned ColW  = 4;
  localparam int unsigned RowW  = 4;
  localparam int unsigned CodeW = 5;
  localparam int unsigned WaitW = 16;

  localparam logic [WaitW-1:0] WAIT_TICKS_RESET = 16'd10;
  localparam logic [ColW-1:0]  COLS_RELEASED    = 4'hF;

  // Row drive patterns during the row search
  localparam logic [RowW-1:0] DRIVE_IDLE      = 4'h0;
  localparam logic [RowW-1:0] DRIVE_PROBE     = 4'hC;
  localparam logic [RowW-1:0] DRIVE_ISO_LOWER = 4'hE;
  localparam logic [RowW-1:0] DRIVE_ISO_UPPER = 4'hB;

  typedef struct packed {
    logic [RowW-1:0]  row_drive;
    logic             key_valid;
    logic [CodeW-1:0] key_code;
  } result_t;

endpackage
`default_nettype wire

// ----- src/kbrs_fsm.sv -----
// Scan sequencer: edge latch, debounce timer, binary row search, key code.
`default_nettype none
module kbrs_fsm import kbrs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [WaitW-1:0] cfg_wr_data,
  input  wire logic             accept,
  input  wire logic [ColW-1:0]  cols,
  output result_t               res_next
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_PROBE    = 3'd2,
    PH_ISOLATE  = 3'd3,
    PH_SETTLE   = 3'd4
  } phase_t;

  logic [WaitW-1:0] wait_ticks;
  phase_t           phase, phase_next;
  logic [WaitW-1:0] wait_count, wait_count_next;
  logic [ColW-1:0]  pending_edges, pending_edges_next;
  logic [ColW-1:0]  previous_columns;
  logic [1:0]       active_column, active_column_next;
  logic [1:0]       found_row, found_row_next;
  logic [ColW-1:0]  edges;
  logic             col_low;

  always_comb begin
    edges              = pending_edges | (previous_columns & ~cols);
    phase_next         = phase;
    wait_count_next    = wait_count;
    pending_edges_next = edges;
    active_column_next = active_column;
    found_row_next     = found_row;
    col_low            = ~cols[active_column];
    res_next.key_valid = 1'b0;
    res_next.key_code  = '0;

    unique case (phase) inside
      PH_DEBOUNCE, PH_PROBE, PH_ISOLATE, PH_SETTLE: begin
        if (wait_count > 16'd1) begin
          wait_count_next = wait_count - 16'd1;
        end else begin
          wait_count_next = wait_ticks;
          case (phase)
            PH_DEBOUNCE: begin
              if (col_low) begin
                phase_next = PH_PROBE;
              end else begin
                // drop only the column that failed debounce
                pending_edges_next = edges & ~(ColW'(1) << active_column);
                phase_next         = PH_IDLE;
                wait_count_next    = '0;
              end
            end
            PH_PROBE: begin
              found_row_next = col_low ? 2'd0 : 2'd2;
              phase_next     = PH_ISOLATE;
            end
            PH_ISOLATE: begin
              if (!col_low) found_row_next = found_row + 2'd1;
              phase_next = PH_SETTLE;
            end
            default: begin
              res_next.key_valid = 1'b1;
              res_next.key_code  = {1'b0, found_row, active_column} + CodeW'(1);
              pending_edges_next = '0;
              phase_next         = PH_IDLE;
              wait_count_next    = '0;
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (edges != '0) begin
          // serve the lowest pending column first
          if (edges[0])      active_column_next = 2'd0;
          else if (edges[1]) active_column_next = 2'd1;
          else if (edges[2]) active_column_next = 2'd2;
          else               active_column_next = 2'd3;
          phase_next      = PH_DEBOUNCE;
          wait_count_next = wait_ticks;
        end
      end
    endcase

    if (phase_next == PH_PROBE)
      res_next.row_drive = DRIVE_PROBE;
    else if (phase_next == PH_ISOLATE)
      res_next.row_drive = found_row_next[1] ? DRIVE_ISO_UPPER : DRIVE_ISO_LOWER;
    else
      res_next.row_drive = DRIVE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks       <= WAIT_TICKS_RESET;
      phase            <= PH_IDLE;
      wait_count       <= '0;
      pending_edges    <= '0;
      previous_columns <= COLS_RELEASED;
      active_column    <= '0;
      found_row        <= '0;
    end else begin
      if (cfg_wr_en) wait_ticks <= cfg_wr_data;
      if (accept) begin
        phase            <= phase_next;
        wait_count       <= wait_count_next;
        pending_edges    <= pending_edges_next;
        previous_columns <= cols;
        active_column    <= active_column_next;
        found_row        <= found_row_next;
      end
    end
  end

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.key_valid) |=> (pending_edges == '0 && phase == PH_IDLE))
    else $error("pending edges not cleared after key report");

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_next.key_valid |-> (res_next.key_code != '0))
    else $error("key report with zero code");

  a_hold_on_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(phase) && $stable(pending_edges) && $stable(wait_count)))
    else $error("scan state moved without a transfer");

endmodule
`default_nettype wire

// ----- src/kbrs_out_queue.sv -----
// Two-entry result queue between the sequencer and the output channel.
`default_nettype none
module kbrs_out_queue import kbrs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         has_room,
  input  wire logic    pop,
  output logic         not_empty,
  output result_t      head
);

  result_t    slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign has_room  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    ((wr_ptr == rd_ptr) == (count == 2'd0 || count == 2'd2)))
    else $error("queue pointers disagree with count");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

// ----- src/keypad_binary_row_scanner_unit.sv -----
// Top level of the 4x4 keypad row scanner.
// Each input transfer is one timer tick of active-low column levels and yields
// exactly one result transfer (row drive, key valid, key code). The scan
// sequencer updates its state from the registered state and the new tick in a
// single pass, and the result goes into a two-entry output queue, so a new tick
// is taken every cycle while the queue has room. The wait_ticks register
// (reset 10) sets the wait of each scan phase (debounce, probe, isolate,
// settle) in ticks; write it only while no result is outstanding.
`default_nettype none
module keypad_binary_row_scanner_unit import kbrs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [WaitW-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ColW-1:0]  column_levels,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [RowW-1:0]       row_drive,
  output logic                  key_valid,
  output logic [CodeW-1:0]      key_code
);

  result_t res_next;
  result_t head;
  logic    accept;
  logic    has_room;

  assign in_ready = has_room;
  assign accept   = in_valid && has_room;

  kbrs_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .cols        (column_levels),
    .res_next    (res_next)
  );

  kbrs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_next),
    .has_room  (has_room),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  assign row_drive = head.row_drive;
  assign key_valid = head.key_valid;
  assign key_code  = head.key_code;

endmodule
`default_nettype wire

// ----- tb/keypad_binary_row_scanner_unit_test.sv -----
// Self-checking testbench for the keypad row scanner: directed keys, then random tick streams.
`timescale 1ns / 1ps
module keypad_binary_row_scanner_unit_test;
  import kbrs_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE     = 3'd0,
    SCAN_DEBOUNCE = 3'd1,
    SCAN_PROBE    = 3'd2,
    SCAN_ISOLATE  = 3'd3,
    SCAN_SETTLE   = 3'd4
  } scan_phase_e;

  localparam int DIRECTED_COUNT  = 23;
  // key col0/row0, key col3/row3, bounce on col1, all columns at once
  localparam logic [DIRECTED_COUNT*ColW-1:0] DIRECTED_TICKS = 92'hFEEEEEFF77FFFFDFF00000F;
  localparam int PHASE_COUNT     = 12;
  localparam logic [PHASE_COUNT*WaitW-1:0] WAIT_SETTINGS = {
    16'd10, 16'd1, 16'd0, 16'd2, 16'd3, 16'd1,
    16'd4, 16'd2, 16'd0, 16'd1, 16'd3, 16'd65535
  };
  localparam int LONG_HOLD       = 60;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTED    = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [WaitW-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ColW-1:0]  column_levels = COLS_RELEASED;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [RowW-1:0]  row_drive;
  logic             key_valid;
  logic [CodeW-1:0] key_code;

  keypad_binary_row_scanner_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .column_levels (column_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .row_drive     (row_drive),
    .key_valid     (key_valid),
    .key_code      (key_code)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Scanner shadow state
  scan_phase_e      scan_phase = SCAN_IDLE;
  logic [WaitW-1:0] wait_setting = WAIT_TICKS_RESET;
  logic [WaitW-1:0] wait_left = '0;
  logic [ColW-1:0]  pending_cols = '0;
  logic [ColW-1:0]  last_cols = COLS_RELEASED;
  logic [1:0]       serving_col = '0;
  logic [1:0]       row_guess = '0;

  logic [ColW-1:0]  pending_ticks [$];
  result_t          expected_scan_results [$];
  int               queued_ticks = 0;
  int               mismatch_count = 0;
  int               send_gap_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;

  function automatic result_t predict_scan_tick(input logic [ColW-1:0] cols);
    result_t res;
    logic    col_low;
    res.key_valid = 1'b0;
    res.key_code  = '0;
    pending_cols  = pending_cols | (last_cols & ~cols);
    last_cols     = cols;
    if (scan_phase != SCAN_IDLE) begin
      if (wait_left > 1) begin
        wait_left = wait_left - 1'b1;
      end else begin
        wait_left = '0;
        col_low   = !cols[serving_col];
        case (scan_phase)
          SCAN_DEBOUNCE: begin
            if (col_low) begin
              scan_phase = SCAN_PROBE;
              wait_left  = wait_setting;
            end else begin
              // bounce: drop only the column being served
              pending_cols[serving_col] = 1'b0;
              scan_phase = SCAN_IDLE;
            end
          end
          SCAN_PROBE: begin
            row_guess  = col_low ? 2'd0 : 2'd2;
            scan_phase = SCAN_ISOLATE;
            wait_left  = wait_setting;
          end
          SCAN_ISOLATE: begin
            if (!col_low) row_guess = row_guess + 2'd1;
            scan_phase = SCAN_SETTLE;
            wait_left  = wait_setting;
          end
          default: begin
            res.key_valid = 1'b1;
            res.key_code  = CodeW'(row_guess) * CodeW'(4) + CodeW'(serving_col) + CodeW'(1);
            pending_cols  = '0;
            scan_phase    = SCAN_IDLE;
          end
        endcase
      end
    end else if (pending_cols != '0) begin
      // serve the lowest pending column
      if (pending_cols[0])      serving_col = 2'd0;
      else if (pending_cols[1]) serving_col = 2'd1;
      else if (pending_cols[2]) serving_col = 2'd2;
      else                      serving_col = 2'd3;
      scan_phase = SCAN_DEBOUNCE;
      wait_left  = wait_setting;
    end
    case (scan_phase)
      SCAN_PROBE:   res.row_drive = DRIVE_PROBE;
      SCAN_ISOLATE: res.row_drive = row_guess[1] ? DRIVE_ISO_UPPER : DRIVE_ISO_LOWER;
      default:      res.row_drive = DRIVE_IDLE;
    endcase
    return res;
  endfunction

  // Tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      column_levels <= COLS_RELEASED;
    end else begin
      if (in_valid && in_ready)
        expected_scan_results.push_back(predict_scan_tick(column_levels));
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          column_levels <= pending_ticks.pop_front();
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.row_drive = row_drive;
        got.key_valid = key_valid;
        got.key_code  = key_code;
        if (expected_scan_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("unexpected result: row_drive=%h key_valid=%b key_code=%0d",
                     got.row_drive, got.key_valid, got.key_code);
        end else begin
          want = expected_scan_results.pop_front();
          if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
              got.key_code !== want.key_code) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
              $display("result mismatch: row_drive exp %h got %h, key_valid exp %b got %b, key_code exp %0d got %0d",
                       want.row_drive, got.row_drive, want.key_valid, got.key_valid,
                       want.key_code, got.key_code);
          end
        end
      end
      // hold off for a long stretch when asked, else stall at random
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("keypad_binary_row_scanner_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_tick(input logic [ColW-1:0] levels);
    pending_ticks.push_back(levels);
    queued_ticks++;
  endtask

  task automatic write_wait_ticks(input logic [WaitW-1:0] value);
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= value;
    wait_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 72; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 72; end
      default: begin send_gap_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Pause the sender until every tick is through and every result is back
  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || in_valid || expected_scan_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One key press: column mostly low, long enough for a full scan unless cut short or wait > 16
  task automatic queue_keystroke(input bit cut_short);
    int unsigned      col;
    int unsigned      len;
    int unsigned      eff;
    int unsigned      i;
    logic [ColW-1:0]  lv;
    eff = (wait_setting == 0) ? 1 : wait_setting;
    col = $urandom_range(0, ColW - 1);
    if (cut_short)
      len = $urandom_range(1, (eff <= 16) ? 2 * eff + 1 : 8);
    else
      len = (eff <= 16) ? 4 * eff + 2 + $urandom_range(0, 3) : $urandom_range(4, 12);
    for (i = 0; i < len; i++) begin
      lv = COLS_RELEASED;
      for (int b = 0; b < ColW; b++)
        if (b == col) lv[b] = ($urandom_range(0, 3) == 0);
        else          lv[b] = ($urandom_range(0, 3) != 0);
      queue_tick(lv);
    end
    repeat ($urandom_range(1, 3)) queue_tick(COLS_RELEASED);
  endtask

  initial begin
    int phase_start;
    int budget;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_wait_ticks(16'd1);
    set_idling(0);
    for (int i = 0; i < DIRECTED_COUNT; i++)
      queue_tick(DIRECTED_TICKS[(DIRECTED_COUNT - 1 - i) * ColW +: ColW]);
    wait_for_drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_wait_ticks(WAIT_SETTINGS[(PHASE_COUNT - 1 - p) * WaitW +: WaitW]);
      set_idling(p % 4);
      budget      = (wait_setting > 16) ? 40 : 75;
      phase_start = queued_ticks;
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_requests++;
      while (queued_ticks - phase_start < budget) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6)      queue_keystroke(1'b0);
        else if (pick == 7) queue_keystroke(1'b1);
        else repeat ($urandom_range(1, 4)) queue_tick(ColW'($urandom_range(0, 15)));
      end
      wait_for_drain();
    end

    if (mismatch_count == 0 && expected_scan_results.size() == 0)
      $display("keypad_binary_row_scanner_unit regression: pass");
    else
      $display("keypad_binary_row_scanner_unit regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/kbrs_pkg.sv
src/kbrs_fsm.sv
src/kbrs_out_queue.sv
src/keypad_binary_row_scanner_unit.sv
tb/keypad_binary_row_scanner_unit_test.sv
